FILE: design/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared widths, request and result codes and the controller state type
// for the token bucket shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // field widths
    localparam int TYPE_W     = 2;
    localparam int AMOUNT_W   = 32;
    localparam int TAG_W      = 8;
    localparam int KIND_W     = 2;
    localparam int RATE_W     = 24;
    localparam int TOK_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // most results one input transaction may cause
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // request types
    localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_QUEUED = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_NOWAIT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NW_GRANT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NW_REFUSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_Q_GRANT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_Q_FULL    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL     = 2'd2;

    // reset values of the registers
    localparam logic [RATE_W-1:0] RATE_RESET     = 24'd1;
    localparam logic [TOK_W-1:0]  CAPACITY_RESET = 40'd65536;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SERVE,
        S_FLUSH
    } t_state;

endpackage

FILE: design/tbs_ram.sv
// ----------------------------------------------------------------------------
// tbs_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read that holds its data between reads.
// ----------------------------------------------------------------------------
module tbs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/token_bucket_shaper.sv
// ----------------------------------------------------------------------------
// token_bucket_shaper
// Token bucket with a first-in first-out wait queue held in a RAM.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_req_type, i_amount, i_req_tag
//   out      output     o_out_valid / i_out_stall o_result_kind, o_grant_tag, o_last
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request is captured while idle and then executed. A tick on an empty
// queue or a push behind a waiting head then returns to idle; a no-wait
// acquire or a rejected acquire first hands out its result. Serving the queue
// reads each head examined from the RAM, then compares it with the tokens and writes back a part-paid head.
// Synchronous active-low reset clears the controller, the queue pointers and
// the tokens and loads the registers' reset values; the RAM needs no clearing.
// A stalled output holds the controller whenever a result is due while the
// output register still holds an earlier one.
// ----------------------------------------------------------------------------
module token_bucket_shaper #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input transactions
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tbs_pkg::TYPE_W-1:0]       i_req_type,
    input  logic [tbs_pkg::AMOUNT_W-1:0]     i_amount,
    input  logic [tbs_pkg::TAG_W-1:0]        i_req_tag,
    // result transactions
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tbs_pkg::KIND_W-1:0]       o_result_kind,
    output logic [tbs_pkg::TAG_W-1:0]        o_grant_tag,
    output logic                             o_last,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import tbs_pkg::*;

    localparam int QA_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = QC_W + 1;
    localparam int ENTRY_W = AMOUNT_W + TAG_W;

    localparam logic [QC_W-1:0]  COUNT_FULL = QC_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(QUEUE_DEPTH);
    localparam logic [QA_W-1:0]  HEAD_LAST  = QA_W'(QUEUE_DEPTH - 1);

    // control state
    t_state               r_state, n_state;
    logic [RATE_W-1:0]    r_rate, n_rate;
    logic [TOK_W-1:0]     r_cap, n_cap;
    logic [TOK_W-1:0]     r_tokens, n_tokens;
    logic [QA_W-1:0]      r_head, n_head;
    logic [QC_W-1:0]      r_count, n_count;
    logic [RES_CNT_W-1:0] r_nres, n_nres;
    logic                 r_pend_valid, n_pend_valid;
    logic                 r_out_valid, n_out_valid;

    // payload registers
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [AMOUNT_W-1:0]  r_amount, n_amount;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [KIND_W-1:0]    r_pend_kind, n_pend_kind;
    logic [TAG_W-1:0]     r_pend_tag, n_pend_tag;
    logic [KIND_W-1:0]    r_out_kind, n_out_kind;
    logic [TAG_W-1:0]     r_out_tag, n_out_tag;
    logic                 r_out_last, n_out_last;

    // ram ports
    logic                 ram_wr_en;
    logic [QA_W-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;

    // datapath
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 out_free;
    logic [SUM_W-1:0]     tail_sum;
    logic [QA_W-1:0]      tail;
    logic [QA_W-1:0]      head_next;
    logic [TOK_W:0]       tick_sum;
    logic [TOK_W-1:0]     tick_tokens;
    logic [TOK_W-1:0]     clamped;
    logic [TOK_W-1:0]     amount_ext;
    logic [AMOUNT_W-1:0]  need;
    logic [TAG_W-1:0]     need_tag;
    logic [TOK_W-1:0]     need_ext;

    tbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (ram_rd_data)
    );

    // handshakes
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;

    // queue pointer arithmetic
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail      = (tail_sum >= DEPTH_S) ? QA_W'(tail_sum - DEPTH_S)
                                             : tail_sum[QA_W-1:0];
    assign head_next = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;

    // token arithmetic
    assign tick_sum    = {1'b0, r_tokens} + (TOK_W + 1)'(r_rate);
    assign tick_tokens = (tick_sum > {1'b0, r_cap}) ? r_cap : tick_sum[TOK_W-1:0];
    assign clamped     = (r_tokens > r_cap) ? r_cap : r_tokens;
    assign amount_ext  = TOK_W'(r_amount);
    assign need        = ram_rd_data[ENTRY_W-1:TAG_W];
    assign need_tag    = ram_rd_data[TAG_W-1:0];
    assign need_ext    = TOK_W'(need);

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_rate       = r_rate;
        n_cap        = r_cap;
        n_tokens     = r_tokens;
        n_head       = r_head;
        n_count      = r_count;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_tag   = r_pend_tag;
        n_type       = r_type;
        n_amount     = r_amount;
        n_tag        = r_tag;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_head;
        ram_wr_data  = {r_amount, r_tag};
        ram_rd_en    = 1'b0;

        // result leaves the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // register writes
                if (cfg_acc) begin
                    case (i_cfg_index)
                        REG_RATE:     n_rate   = i_cfg_data[RATE_W-1:0];
                        REG_CAPACITY: n_cap    = i_cfg_data[TOK_W-1:0];
                        REG_FILL:     n_tokens = i_cfg_data[TOK_W-1:0];
                        default:      ;
                    endcase
                end
                // capture the input transaction
                if (in_acc) begin
                    n_type   = i_req_type;
                    n_amount = i_amount;
                    n_tag    = i_req_tag;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_nres = '0;
                case (r_type)
                    REQ_TICK: begin
                        n_tokens = tick_tokens;
                        n_state  = (r_count != '0) ? S_READ : S_IDLE;
                    end
                    REQ_QUEUED: begin
                        n_tokens = clamped;
                        if (r_count == COUNT_FULL) begin
                            n_pend_valid = 1'b1;
                            n_pend_kind  = KIND_Q_FULL;
                            n_pend_tag   = r_tag;
                            n_state      = S_FLUSH;
                        end else begin
                            // push at the tail, serve at once if queue was empty
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = tail;
                            n_count     = r_count + 1'b1;
                            n_state     = (r_count == '0) ? S_READ : S_IDLE;
                        end
                    end
                    REQ_NOWAIT: begin
                        n_pend_valid = 1'b1;
                        n_pend_tag   = r_tag;
                        n_state      = S_FLUSH;
                        if (clamped >= amount_ext) begin
                            n_tokens    = clamped - amount_ext;
                            n_pend_kind = KIND_NW_GRANT;
                        end else begin
                            n_tokens    = clamped;
                            n_pend_kind = KIND_NW_REFUSE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_READ: begin
                ram_rd_en = 1'b1;
                n_state   = S_SERVE;
            end

            S_SERVE: begin
                if (need_ext > r_tokens) begin
                    // head not covered: it takes all tokens and keeps the rest
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_head;
                    ram_wr_data = {need - r_tokens[AMOUNT_W-1:0], need_tag};
                    n_tokens    = '0;
                    n_state     = r_pend_valid ? S_FLUSH : S_IDLE;
                end else if (!r_pend_valid || out_free) begin
                    // head covered: grant it, the earlier grant is not the last
                    n_tokens = r_tokens - need_ext;
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_tag   = r_pend_tag;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_kind  = KIND_Q_GRANT;
                    n_pend_tag   = need_tag;
                    n_head       = head_next;
                    n_count      = r_count - 1'b1;
                    n_nres       = r_nres + 1'b1;
                    if (r_count == QC_W'(1) ||
                        r_nres == RES_CNT_W'(MAX_RESULTS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end

            S_FLUSH: begin
                // final result of the item
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_tag    = r_pend_tag;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rate       <= RATE_RESET;
            r_cap        <= CAPACITY_RESET;
            r_tokens     <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rate       <= n_rate;
            r_cap        <= n_cap;
            r_tokens     <= n_tokens;
            r_head       <= n_head;
            r_count      <= n_count;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_type      <= n_type;
        r_amount    <= n_amount;
        r_tag       <= n_tag;
        r_pend_kind <= n_pend_kind;
        r_pend_tag  <= n_pend_tag;
        r_out_kind  <= n_out_kind;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_grant_tag   = r_out_tag;
    assign o_last        = r_out_last;

endmodule

FILE: design/tbs_check.sv
// ----------------------------------------------------------------------------
// tbs_check
// Port-level checks for the token bucket shaper, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic [tbs_pkg::KIND_W-1:0]       o_result_kind,
    input  logic [tbs_pkg::TAG_W-1:0]        o_grant_tag,
    input  logic                             o_last,
    input  logic                             o_cfg_ready
);

    import tbs_pkg::*;

    // a result held back by the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_result_kind) && $stable(o_grant_tag) && $stable(o_last))
        else $error("stalled result changed");

    // an accepted request keeps the input closed while it is worked on
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !o_cfg_ready)
        else $error("second request taken while busy");

    // no-wait answers and queue-full rejections are single results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_NW_GRANT ||
                        o_result_kind == KIND_NW_REFUSE ||
                        o_result_kind == KIND_Q_FULL) |-> o_last)
        else $error("single result not marked last");

    // results only come out of a request being worked on
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

endmodule

bind token_bucket_shaper tbs_check u_tbs_check (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for token_bucket_shaper. A bucket predictor in the
// testbench tracks tokens, registers and the wait queue, and queues the
// expected results of every accepted request. Each result transaction is
// compared field by field with the oldest expectation. Directed tests cover
// the corner cases and one long output hold-off. Random traffic then runs
// under several register settings, in most phases with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import tbs_pkg::*;

    localparam int Q_DEPTH       = 16;
    // settle time for the worst item, with margin
    localparam int SETTLE_CYCLES = 2 + 2 * MAX_RESULTS + 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRESSURE_HOLD = 400;
    localparam int PHASE_ITEMS   = 45;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [RATE_W-1:0] RATE_MAX   = '1;
    localparam logic [TOK_W-1:0]  TOK_MAX    = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } t_shaper_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [TYPE_W-1:0]     i_req_type  = '0;
    logic [AMOUNT_W-1:0]   i_amount    = '0;
    logic [TAG_W-1:0]      i_req_tag   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KIND_W-1:0]     o_result_kind;
    logic [TAG_W-1:0]      o_grant_tag;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // bucket predictor state
    logic [RATE_W-1:0]     bkt_rate;
    logic [TOK_W-1:0]      bkt_capacity;
    logic [TOK_W-1:0]      bkt_tokens;
    logic [AMOUNT_W-1:0]   wq_amount [Q_DEPTH];
    logic [TAG_W-1:0]      wq_tag [Q_DEPTH];
    int unsigned           wq_head;
    int unsigned           wq_count;
    t_shaper_result        pending_results[$];

    int                    n_errors      = 0;
    int                    quiet_cycles  = 0;
    int                    hold_request  = 0;
    int                    stall_left    = 0;
    bit                    idle_on       = 1'b1;

    token_bucket_shaper #(
        .QUEUE_DEPTH(Q_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_amount     (i_amount),
        .i_req_tag    (i_req_tag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_kind(o_result_kind),
        .o_grant_tag  (o_grant_tag),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag);
        t_shaper_result r;
        r.kind = kind;
        r.tag  = tag;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // pay queue heads until the bucket runs dry or the result cap is hit
    function automatic int serve_wait_queue(int n);
        int unsigned h;
        int          cnt;
        cnt = n;
        while (wq_count > 0 && cnt < MAX_RESULTS) begin
            h = wq_head;
            if (TOK_W'(wq_amount[h]) > bkt_tokens) begin
                wq_amount[h] = wq_amount[h] - AMOUNT_W'(bkt_tokens);
                bkt_tokens   = '0;
                break;
            end
            bkt_tokens = bkt_tokens - TOK_W'(wq_amount[h]);
            push_result(KIND_Q_GRANT, wq_tag[h]);
            cnt++;
            wq_head  = (h + 1) % Q_DEPTH;
            wq_count = wq_count - 1;
        end
        return cnt;
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(logic [TYPE_W-1:0] rtype,
                                            logic [AMOUNT_W-1:0] amt,
                                            logic [TAG_W-1:0] tag);
        logic [TOK_W:0]  sum;
        int              n;
        int unsigned     slot;
        bit              was_empty;
        t_shaper_result  r;
        n = 0;
        // acquires see the bucket clamped to capacity first
        if ((rtype == REQ_QUEUED || rtype == REQ_NOWAIT) && bkt_tokens > bkt_capacity)
            bkt_tokens = bkt_capacity;
        case (rtype)
            REQ_TICK: begin
                sum = (TOK_W+1)'(bkt_tokens) + (TOK_W+1)'(bkt_rate);
                bkt_tokens = (sum > (TOK_W+1)'(bkt_capacity)) ? bkt_capacity
                                                               : sum[TOK_W-1:0];
                n = serve_wait_queue(0);
            end
            REQ_QUEUED: begin
                if (wq_count >= Q_DEPTH) begin
                    push_result(KIND_Q_FULL, tag);
                    n = 1;
                end else begin
                    was_empty       = (wq_count == 0);
                    slot            = (wq_head + wq_count) % Q_DEPTH;
                    wq_amount[slot] = amt;
                    wq_tag[slot]    = tag;
                    wq_count        = wq_count + 1;
                    if (was_empty) n = serve_wait_queue(0);
                end
            end
            REQ_NOWAIT: begin
                if (bkt_tokens >= TOK_W'(amt)) begin
                    bkt_tokens = bkt_tokens - TOK_W'(amt);
                    push_result(KIND_NW_GRANT, tag);
                end else begin
                    push_result(KIND_NW_REFUSE, tag);
                end
                n = 1;
            end
            default: ;
        endcase
        // mark the final result of this request
        if (n > 0) begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    // one request transaction, with an optional gap before it
    task automatic send_request(input logic [TYPE_W-1:0] rtype,
                                input logic [AMOUNT_W-1:0] amt,
                                input logic [TAG_W-1:0] tag);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rtype;
        i_amount   <= amt;
        i_req_tag  <= tag;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(rtype, amt, tag);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RATE:     bkt_rate     = data[RATE_W-1:0];
            REG_CAPACITY: bkt_capacity = data[TOK_W-1:0];
            REG_FILL:     bkt_tokens   = data[TOK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // no-wait grant and refusal, tick on empty queue, immediate and partial serve
    task automatic test_basic_requests();
        write_reg(REG_RATE, 40'd10);
        write_reg(REG_CAPACITY, 40'd1000);
        write_reg(REG_FILL, 40'd500);
        send_request(REQ_NOWAIT, 32'd0, 8'h00);
        send_request(REQ_NOWAIT, 32'd500, 8'h11);
        send_request(REQ_NOWAIT, 32'd1, 8'h22);
        send_request(REQ_TICK, 32'hA5A5_5A5A, 8'h5A);
        send_request(REQ_QUEUED, 32'd0, 8'h33);
        send_request(REQ_QUEUED, 32'd25, 8'h44);
        send_request(REQ_UNUSED, 32'd7, 8'h55);
        drain_results();
    endtask

    // fill above capacity: acquires clamp before paying
    task automatic test_bucket_clamp();
        write_reg(REG_CAPACITY, 40'd100);
        write_reg(REG_FILL, 40'd1000);
        send_request(REQ_NOWAIT, 32'd101, 8'h66);
        send_request(REQ_NOWAIT, 32'd100, 8'h77);
        drain_results();
    endtask

    // fill the wait queue, reject one more, then release all heads at once
    task automatic test_queue_full();
        logic [AMOUNT_W-1:0] amt;
        for (int i = 0; i < Q_DEPTH - 1; i++) begin
            if (i == 0) amt = '1;
            else if (i == 1) amt = '0;
            else amt = AMOUNT_W'($urandom_range(1, 1000));
            send_request(REQ_QUEUED, amt, 8'(8'h80 + i));
        end
        send_request(REQ_QUEUED, 32'd0, 8'hFF);
        drain_results();
        write_reg(REG_RATE, CFG_DATA_W'(RATE_MAX));
        write_reg(REG_CAPACITY, TOK_MAX);
        write_reg(REG_FILL, TOK_MAX);
        send_request(REQ_TICK, 32'd0, 8'h00);
        drain_results();
    endtask

    // long output hold-off while requests keep coming
    task automatic test_backpressure();
        write_reg(REG_RATE, 40'd5000);
        write_reg(REG_CAPACITY, 40'd1000000);
        write_reg(REG_FILL, 40'd1000000);
        idle_on      = 1'b0;
        hold_request = PRESSURE_HOLD;
        for (int i = 0; i < 40; i++) begin
            send_request((i % 3 == 0) ? REQ_NOWAIT : REQ_QUEUED,
                         AMOUNT_W'($urandom_range(0, 20000)), 8'(i));
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    // random traffic under a series of register settings
    task automatic test_random_traffic();
        longint unsigned     rate;
        longint unsigned     cap;
        longint unsigned     fill;
        longint unsigned     span;
        logic [TYPE_W-1:0]   rtype;
        logic [AMOUNT_W-1:0] amt;
        int                  sent;
        int                  r;
        for (int ph = 0; ph < 9; ph++) begin
            idle_on = (ph % 3) != 1;
            // usually empty the wait queue so old heads do not block the phase
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_CAPACITY, TOK_MAX);
                write_reg(REG_FILL, TOK_MAX);
                send_request(REQ_TICK, $urandom(), 8'($urandom()));
                drain_results();
            end
            case ($urandom_range(0, 3))
                0:       rate = 1;
                1:       rate = RATE_MAX;
                2:       rate = $urandom_range(1, 300);
                default: rate = $urandom_range(1, 32'(RATE_MAX));
            endcase
            case ($urandom_range(0, 9))
                0:       cap = 0;
                1, 2:    cap = TOK_MAX;
                3, 4:    cap = (64'($urandom_range(0, 255)) << 32) | 64'($urandom());
                default: cap = rate * $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0:       fill = 0;
                1:       fill = cap;
                2:       fill = TOK_MAX;
                default: fill = cap / $urandom_range(1, 4);
            endcase
            write_reg(REG_RATE, CFG_DATA_W'(rate));
            write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
            write_reg(REG_FILL, CFG_DATA_W'(fill));

            span = rate * 2;
            if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 45) rtype = REQ_TICK;
                else if (r < 70) rtype = REQ_QUEUED;
                else if (r < 95) rtype = REQ_NOWAIT;
                else rtype = REQ_UNUSED;
                r = $urandom_range(0, 39);
                if (r < 4) amt = '0;
                else if (r == 4 || (r < 9 && rtype != REQ_QUEUED)) amt = $urandom();
                else amt = AMOUNT_W'($urandom_range(0, 32'(span)));
                send_request(rtype, amt, 8'($urandom()));
                if (rtype != REQ_UNUSED) sent++;
                // sender pause until the block has caught up
                if ($urandom_range(0, 49) == 0) drain_results();
            end
            drain_results();
        end
    endtask

    // receiver stall: random stretches, or a requested long hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on) stall_left = pick_gap();
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_shaper_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d tag 0x%02h last %0b",
                       o_result_kind, o_grant_tag, o_last);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_kind !== exp_r.kind) begin
                    $error("result_kind: expected %0d, actual %0d", exp_r.kind, o_result_kind);
                    n_errors++;
                end
                if (o_grant_tag !== exp_r.tag) begin
                    $error("grant_tag: expected 0x%02h, actual 0x%02h", exp_r.tag, o_grant_tag);
                    n_errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0b, actual %0b", exp_r.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        bkt_rate     = RATE_RESET;
        bkt_capacity = CAPACITY_RESET;
        bkt_tokens   = '0;
        wq_head      = 0;
        wq_count     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_requests();
        test_bucket_clamp();
        test_queue_full();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: token_bucket_shaper.f
design/tbs_pkg.sv
design/tbs_ram.sv
design/token_bucket_shaper.sv
design/tbs_check.sv
dv/tb_top.sv
